// ===== rtl/ramiot_pkg.sv =====
// shared types and constants for the ram, i/o port and timer block
`timescale 1ns / 1ps

package ramiot_pkg;

    localparam int RAM_DEPTH = 256;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int DATA_W    = 8;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_RAM_RD = 3'd1;
    localparam logic [2:0] OP_RAM_WR = 3'd2;
    localparam logic [2:0] OP_REG_RD = 3'd3;
    localparam logic [2:0] OP_REG_WR = 3'd4;

    localparam logic [2:0] REG_CMD = 3'd0;
    localparam logic [2:0] REG_PA  = 3'd1;
    localparam logic [2:0] REG_PB  = 3'd2;
    localparam logic [2:0] REG_PC  = 3'd3;
    localparam logic [2:0] REG_TLO = 3'd4;
    localparam logic [2:0] REG_THI = 3'd5;

    localparam logic [1:0] TCMD_NOP     = 2'b00;
    localparam logic [1:0] TCMD_STOP    = 2'b01;
    localparam logic [1:0] TCMD_STOP_TC = 2'b10;
    localparam logic [1:0] TCMD_START   = 2'b11;

    localparam logic [1:0] PC_ALT1 = 2'b00;
    localparam logic [1:0] PC_ALT2 = 2'b11;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [7:0]        address;
        logic [DATA_W-1:0] write_data;
        logic [7:0]        pa_pins;
        logic [7:0]        pb_pins;
        logic [5:0]        pc_pins;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [7:0]        port_a_out;
        logic [7:0]        port_b_out;
        logic [5:0]        port_c_out;
        logic              port_a_drive;
        logic              port_b_drive;
        logic              port_c_drive;
        logic              timer_pin;
    } out_t;

endpackage

// ===== rtl/ramiot_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module ramiot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/ramiot_regs.sv =====
// command, port latches, status and timer registers with their update logic
`timescale 1ns / 1ps

module ramiot_regs (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   process,
    input  ramiot_pkg::in_t        item,
    input  logic [7:0]             ram_byte,
    output ramiot_pkg::out_t       result
);
    import ramiot_pkg::*;

    typedef struct packed {
        logic [7:0]  cmd;
        logic        flag;
        logic [7:0]  la;
        logic [7:0]  lb;
        logic [5:0]  lc;
        logic [15:0] assigned;
        logic [15:0] loaded;
        logic        pin;
        logic        second;
        logic [13:0] half_rem;
        logic        half_run;
        logic [12:0] pulse_rem;
        logic        pulse_run;
    } tmr_t;

    tmr_t        st_reg;
    tmr_t        st_next;
    logic [15:0] cur_cnt;
    logic [7:0]  rd;

    // everything clear, timer pin high
    function automatic tmr_t reset_state();
        tmr_t r;
        r     = '0;
        r.pin = 1'b1;
        return r;
    endfunction

    function automatic logic [15:0] cur_count(tmr_t s);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] v;
        a = {1'b0, s.half_rem + 14'd1, 1'b0};
        b = {2'b00, s.loaded[13:1], 1'b0};
        v = (a < b) ? a : b;
        if (s.half_run) begin
            return {v[15:1], ~s.second};
        end
        return s.assigned;
    endfunction

    function automatic tmr_t stop_cnt(tmr_t s);
        tmr_t r;
        r = s;
        if (s.half_run) begin
            r.loaded   = (s.loaded & 16'hc000) | cur_count(s);
            r.half_run = 1'b0;
        end
        r.pulse_run = 1'b0;
        r.pin       = 1'b1;
        return r;
    endfunction

    function automatic tmr_t reload_cnt(tmr_t s);
        tmr_t r;
        r = s;
        r.loaded = s.assigned;
        if (s.assigned[13:0] < 14'd2) begin
            r = stop_cnt(r);
        end else begin
            r.second   = 1'b0;
            r.half_rem = {1'b0, s.assigned[13:1]} + {13'd0, s.assigned[0]};
            r.half_run = 1'b1;
            r.pin      = 1'b1;
        end
        return r;
    endfunction

    function automatic tmr_t half_done(tmr_t s);
        tmr_t r;
        r = s;
        if (s.second) begin
            r.pin    = 1'b1;
            r.second = 1'b0;
            if (!s.loaded[15]) begin
                r.flag = 1'b1;
            end
            if (!s.loaded[14] || s.cmd[7:6] == TCMD_STOP_TC) begin
                r = stop_cnt(r);
            end else begin
                r = reload_cnt(r);
            end
        end else begin
            r.half_rem = {1'b0, s.loaded[13:1]};
            r.half_run = 1'b1;
            r.second   = 1'b1;
            if (!s.loaded[15]) begin
                r.pin = 1'b0;
            end else begin
                r.pulse_rem = (s.loaded[13:1] == 13'd0) ? 13'd0 : s.loaded[13:1] - 13'd1;
                r.pulse_run = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic tmr_t tick_fn(tmr_t s);
        tmr_t r;
        r = s;
        if (r.pulse_run) begin
            if (r.pulse_rem <= 13'd1) begin
                r.pulse_run = 1'b0;
                r.pulse_rem = 13'd0;
                if (r.loaded[15]) begin
                    r.pin = 1'b0;
                end
                r.flag = 1'b1;
            end else begin
                r.pulse_rem = r.pulse_rem - 13'd1;
            end
        end
        if (r.half_run) begin
            if (r.half_rem <= 14'd1) begin
                r.half_run = 1'b0;
                r.half_rem = 14'd0;
                r = half_done(r);
            end else begin
                r.half_rem = r.half_rem - 14'd1;
            end
        end
        return r;
    endfunction

    assign cur_cnt = cur_count(st_reg);

    always_comb begin
        st_next = st_reg;
        rd      = 8'h00;
        if (process) begin
            unique case (item.opcode)
                OP_TICK: begin
                    st_next = tick_fn(st_reg);
                end
                OP_RAM_RD: begin
                    rd = ram_byte;
                end
                OP_REG_RD: begin
                    unique case (item.address[2:0])
                        REG_CMD: begin
                            rd           = {1'b0, st_reg.flag, 6'd0};
                            st_next.flag = 1'b0;
                        end
                        REG_PA: rd = st_reg.cmd[0] ? st_reg.la : item.pa_pins;
                        REG_PB: rd = st_reg.cmd[1] ? st_reg.lb : item.pb_pins;
                        REG_PC: begin
                            unique case (st_reg.cmd[3:2])
                                PC_ALT1: rd = {2'b11, item.pc_pins};
                                PC_ALT2: rd = {2'b11, st_reg.lc};
                                default: rd = 8'hc0;
                            endcase
                        end
                        REG_TLO: rd = cur_cnt[7:0];
                        REG_THI: rd = {st_reg.loaded[15:14], cur_cnt[13:8]};
                        default: rd = 8'h00;
                    endcase
                end
                OP_REG_WR: begin
                    unique case (item.address[2:0])
                        REG_CMD: begin
                            st_next.cmd = item.write_data;
                            unique case (item.write_data[7:6])
                                TCMD_STOP: st_next = stop_cnt(st_next);
                                TCMD_START: begin
                                    if (!st_reg.half_run) begin
                                        st_next = reload_cnt(st_next);
                                    end
                                end
                                default: ;
                            endcase
                        end
                        REG_PA:  st_next.la = item.write_data;
                        REG_PB:  st_next.lb = item.write_data;
                        REG_PC:  st_next.lc = item.write_data[5:0];
                        REG_TLO: st_next.assigned[7:0]  = item.write_data;
                        REG_THI: st_next.assigned[15:8] = item.write_data;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= reset_state();
        end else begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        result.read_data    = rd;
        result.port_a_out   = st_next.la;
        result.port_b_out   = st_next.lb;
        result.port_c_out   = st_next.lc;
        result.port_a_drive = st_next.cmd[0];
        result.port_b_drive = st_next.cmd[1];
        result.port_c_drive = (st_next.cmd[3:2] == PC_ALT2);
        result.timer_pin    = st_next.pin;
    end

endmodule

// ===== rtl/ram_io_port_timer_device_core.sv =====
// top level: 256-byte ram, three i/o ports and a 14-bit timer behind valid/ready channels
`timescale 1ns / 1ps

// s_valid/s_ready/s_data carry one item per transfer: a timer tick, a ram read
// or write, or a register read or write, with the current pin levels of the ports.
// m_valid/m_ready/m_data return exactly one result per item, in order: the read
// byte (zero for ticks and writes) and the port latches, drive enables and timer
// pin as they stand after that item.
// the item is registered in the input stage and the result in the output register;
// the ram read is issued at the transfer edge and its registered data meets the
// item in the input stage, where the register and timer update is done.
// throughput: one item per cycle while m_ready is high; the input stage and the output
// register are separate, so a new item is taken while a result waits.
// when m_ready is low the result holds, one more item is held in the input
// stage, and s_ready drops only when both are full.
// reset (aresetn low, synchronous) empties both stages, clears the command,
// latches, status and timer with the timer pin high, and marks every ram byte
// as zero through per-byte valid bits; no clearing pass is needed.
module ram_io_port_timer_device_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ramiot_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ramiot_pkg::out_t m_data
);
    import ramiot_pkg::*;

    logic                 s_accept;
    logic                 process;
    logic                 in_valid_reg;
    in_t                  in_reg;
    logic                 out_valid_reg;
    out_t                 out_reg;
    out_t                 result;
    logic [RAM_DEPTH-1:0] ram_valid_reg;
    logic                 rd_valid_reg;
    logic [RAM_AW-1:0]    ram_addr;
    logic                 ram_we;
    logic                 ram_re;
    logic [DATA_W-1:0]    ram_rdata;
    logic [DATA_W-1:0]    ram_byte;

    assign s_accept = s_valid && s_ready;
    assign process  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || process;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign ram_addr = s_data.address[RAM_AW-1:0];
    assign ram_we   = s_accept && (s_data.opcode == OP_RAM_WR);
    assign ram_re   = s_accept && (s_data.opcode == OP_RAM_RD);
    assign ram_byte = rd_valid_reg ? ram_rdata : '0;

    ramiot_ram #(
        .WIDTH(DATA_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(s_data.write_data),
        .re   (ram_re),
        .raddr(ram_addr),
        .rdata(ram_rdata)
    );

    ramiot_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .process (process),
        .item    (in_reg),
        .ram_byte(ram_byte),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ram_valid_reg <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end
            if (process) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                ram_valid_reg[ram_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_data;
        end
        if (ram_re) begin
            rd_valid_reg <= ram_valid_reg[ram_addr];
        end
        if (process) begin
            out_reg <= result;
        end
    end

    // reset empties both stages
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("pipeline not empty after reset");

    // an accepted transfer always lands in the input stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted item lost");

    // a processed item always produces a result
    a_process_result: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> m_valid)
        else $error("processed item produced no result");

    // only reads return data
    a_read_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        process && in_reg.opcode != OP_RAM_RD && in_reg.opcode != OP_REG_RD
        |=> m_data.read_data == 8'h00)
        else $error("nonzero read data for a non-read item");

endmodule

// ===== sim/ram_io_port_timer_device_core_test.sv =====
// self-checking testbench for the ram, i/o port and timer core
`timescale 1ns / 1ps

module ram_io_port_timer_device_core_test;
    import ramiot_pkg::*;

    localparam logic [2:0]  OP_UNUSED    = 3'd5;
    localparam logic [2:0]  REG_NONE     = 3'd6;
    localparam logic [15:0] CNT_EVEN     = 16'h3ffe;
    localparam logic [15:0] CNT_MASK     = 16'h3fff;
    localparam logic [7:0]  PC_FIXED     = 8'hc0;
    localparam logic [7:0]  TC_STATUS    = 8'h40;
    localparam int          PHASE_ITEMS  = 317;

    typedef struct packed {
        in_t  item;
        logic typed;
        out_t value;
    } dir_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    ram_io_port_timer_device_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predicted device state
    logic [7:0]  ram_img [RAM_DEPTH];
    logic [7:0]  cmd_img;
    logic        tflag;
    logic [7:0]  latch_a;
    logic [7:0]  latch_b;
    logic [5:0]  latch_c;
    logic [15:0] len_assigned;
    logic [15:0] len_loaded;
    logic        pin_lvl;
    logic        in_second;
    logic [15:0] half_left;
    logic        half_on;
    logic [15:0] pulse_left;
    logic        pulse_on;

    out_t     snapshot_q [$];
    dir_row_t dir_rows [$];

    logic row_typed;
    out_t row_value;
    int   s_idle_pct;
    int   m_idle_pct;
    int   errors;
    int   n_sent;
    int   n_accepted;
    int   n_checked;
    int   n_ticks;
    int   n_tc;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void model_init();
        ram_img      = '{default: 8'h00};
        cmd_img      = 8'h00;
        tflag        = 1'b0;
        latch_a      = 8'h00;
        latch_b      = 8'h00;
        latch_c      = 6'h00;
        len_assigned = 16'h0000;
        len_loaded   = 16'h0000;
        pin_lvl      = 1'b1;
        in_second    = 1'b0;
        half_left    = 16'h0000;
        half_on      = 1'b0;
        pulse_left   = 16'h0000;
        pulse_on     = 1'b0;
    endfunction

    function automatic logic [15:0] count_now();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] v;
        if (half_on) begin
            a = (half_left + 16'd1) << 1;
            b = len_loaded & CNT_EVEN;
            v = (a < b) ? a : b;
            return v | {15'd0, ~in_second};
        end
        return len_assigned;
    endfunction

    function automatic void timer_stop();
        if (half_on) begin
            len_loaded = (len_loaded & ~CNT_MASK) | count_now();
            half_on = 1'b0;
        end
        pulse_on = 1'b0;
        pin_lvl  = 1'b1;
    endfunction

    function automatic void timer_reload();
        len_loaded = len_assigned;
        if ((len_assigned & CNT_MASK) < 16'd2) begin
            timer_stop();
        end else begin
            in_second = 1'b0;
            half_left = ((len_assigned & CNT_EVEN) >> 1) + {15'd0, len_assigned[0]};
            half_on   = 1'b1;
            pin_lvl   = 1'b1;
        end
    endfunction

    function automatic void half_expired();
        logic [15:0] even;
        logic [15:0] e;
        if (in_second) begin
            pin_lvl   = 1'b1;
            in_second = 1'b0;
            if (!len_loaded[15]) begin
                tflag = 1'b1;
                n_tc++;
            end
            if (!len_loaded[14] || cmd_img[7:6] == TCMD_STOP_TC) timer_stop();
            else timer_reload();
        end else begin
            even      = len_loaded & CNT_EVEN;
            half_left = even >> 1;
            half_on   = 1'b1;
            in_second = 1'b1;
            if (!len_loaded[15]) begin
                pin_lvl = 1'b0;
            end else begin
                e          = (even < 16'd2) ? 16'd2 : even;
                pulse_left = (e - 16'd2) >> 1;
                pulse_on   = 1'b1;
            end
        end
    endfunction

    function automatic void timer_tick();
        if (pulse_on) begin
            if (pulse_left <= 16'd1) begin
                pulse_on   = 1'b0;
                pulse_left = 16'd0;
                if (len_loaded[15]) pin_lvl = 1'b0;
                tflag = 1'b1;
                n_tc++;
            end else begin
                pulse_left--;
            end
        end
        if (half_on) begin
            if (half_left <= 16'd1) begin
                half_on   = 1'b0;
                half_left = 16'd0;
                half_expired();
            end else begin
                half_left--;
            end
        end
    endfunction

    function automatic out_t device_step(in_t it);
        out_t        o;
        logic [7:0]  rd;
        logic [15:0] c;
        rd = 8'h00;
        case (it.opcode)
            OP_TICK: begin
                timer_tick();
            end
            OP_RAM_RD: rd = ram_img[RAM_AW'(int'(it.address) % RAM_DEPTH)];
            OP_RAM_WR: ram_img[RAM_AW'(int'(it.address) % RAM_DEPTH)] = it.write_data;
            OP_REG_RD: begin
                c = count_now();
                case (it.address[2:0])
                    REG_CMD: begin
                        rd    = tflag ? TC_STATUS : 8'h00;
                        tflag = 1'b0;
                    end
                    REG_PA:  rd = cmd_img[0] ? latch_a : it.pa_pins;
                    REG_PB:  rd = cmd_img[1] ? latch_b : it.pb_pins;
                    REG_PC: begin
                        case (cmd_img[3:2])
                            PC_ALT1: rd = {2'b00, it.pc_pins} | PC_FIXED;
                            PC_ALT2: rd = {2'b00, latch_c} | PC_FIXED;
                            default: rd = PC_FIXED;
                        endcase
                    end
                    REG_TLO: rd = c[7:0];
                    REG_THI: rd = {len_loaded[15:14], c[13:8]};
                    default: rd = 8'h00;
                endcase
            end
            OP_REG_WR: begin
                case (it.address[2:0])
                    REG_CMD: begin
                        cmd_img = it.write_data;
                        case (it.write_data[7:6])
                            TCMD_STOP:  timer_stop();
                            TCMD_START: if (!half_on) timer_reload();
                            default: ;
                        endcase
                    end
                    REG_PA:  latch_a = it.write_data;
                    REG_PB:  latch_b = it.write_data;
                    REG_PC:  latch_c = it.write_data[5:0];
                    REG_TLO: len_assigned[7:0] = it.write_data;
                    REG_THI: len_assigned[15:8] = it.write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
        o.read_data    = rd;
        o.port_a_out   = latch_a;
        o.port_b_out   = latch_b;
        o.port_c_out   = latch_c;
        o.port_a_drive = cmd_img[0];
        o.port_b_drive = cmd_img[1];
        o.port_c_drive = (cmd_img[3:2] == PC_ALT2);
        o.timer_pin    = pin_lvl;
        return o;
    endfunction

    function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // prediction on every input transfer, check on every output transfer
    always @(posedge aclk) begin
        out_t w;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_data.opcode == OP_TICK) n_ticks++;
                w = device_step(s_data);
                snapshot_q.push_back(row_typed ? row_value : w);
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                if (snapshot_q.size() == 0) begin
                    $error("result transfer with no item pending");
                    errors++;
                end else begin
                    w = snapshot_q.pop_front();
                    cmp_field("read_data", w.read_data, m_data.read_data);
                    cmp_field("port_a_out", w.port_a_out, m_data.port_a_out);
                    cmp_field("port_b_out", w.port_b_out, m_data.port_b_out);
                    cmp_field("port_c_out", 8'(w.port_c_out), 8'(m_data.port_c_out));
                    cmp_field("port_a_drive", 8'(w.port_a_drive), 8'(m_data.port_a_drive));
                    cmp_field("port_b_drive", 8'(w.port_b_drive), 8'(m_data.port_b_drive));
                    cmp_field("port_c_drive", 8'(w.port_c_drive), 8'(m_data.port_c_drive));
                    cmp_field("timer_pin", 8'(w.timer_pin), 8'(m_data.timer_pin));
                    n_checked++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    task automatic push_item(in_t it, logic typed, out_t value);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        row_typed = typed;
        row_value = value;
        s_valid  <= 1'b1;
        s_data   <= it;
        if (it.opcode <= OP_REG_WR) n_sent++;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic in_t bus_item(logic [2:0] op, logic [7:0] addr, logic [7:0] data);
        in_t it;
        it.opcode     = op;
        it.address    = addr;
        it.write_data = data;
        it.pa_pins    = 8'($urandom_range(255));
        it.pb_pins    = 8'($urandom_range(255));
        it.pc_pins    = 6'($urandom_range(63));
        return it;
    endfunction

    function automatic logic [7:0] reg_addr(logic [2:0] off);
        logic [4:0] hi;
        hi = 5'($urandom_range(31));
        return {hi, off};
    endfunction

    task automatic send(logic [2:0] op, logic [7:0] addr, logic [7:0] data);
        push_item(bus_item(op, addr, data), 1'b0, '0);
    endtask

    task automatic send_noise();
        send(3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic timer_burst();
        logic [13:0] len;
        logic [1:0]  mode;
        logic [1:0]  tcmd;
        logic [5:0]  ports;
        int          r;
        r     = $urandom_range(99);
        len   = (r < 70) ? 14'($urandom_range(2, 24)) :
                (r < 80) ? 14'($urandom_range(0, 1)) :
                (r < 84) ? 14'h3fff : 14'($urandom_range(16383));
        mode  = 2'($urandom_range(3));
        ports = 6'($urandom_range(63));
        tcmd  = ($urandom_range(9) < 8) ? TCMD_START : 2'($urandom_range(3));
        send(OP_REG_WR, reg_addr(REG_TLO), len[7:0]);
        send(OP_REG_WR, reg_addr(REG_THI), {mode, len[13:8]});
        send(OP_REG_WR, reg_addr(REG_CMD), {tcmd, ports});
        repeat ($urandom_range(4, 48)) begin
            r = $urandom_range(99);
            if (r < 72) begin
                send(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end else if (r < 80) begin
                send(OP_REG_RD, reg_addr(REG_CMD), 8'($urandom_range(255)));
            end else if (r < 88) begin
                send(OP_REG_RD, reg_addr(r[0] ? REG_TLO : REG_THI), 8'($urandom_range(255)));
            end else if (r < 94) begin
                send(OP_REG_WR, reg_addr(REG_CMD), {2'($urandom_range(3)), ports});
            end else if (r < 97) begin
                send(OP_REG_WR, reg_addr(r[0] ? REG_TLO : REG_THI), 8'($urandom_range(255)));
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic ram_burst();
        logic [7:0] hot;
        logic [7:0] addr;
        hot = 8'($urandom_range(255));
        repeat ($urandom_range(2, 12)) begin
            addr = $urandom_range(1) ? hot : 8'($urandom_range(255));
            if ($urandom_range(1)) begin
                send(OP_RAM_WR, addr, 8'($urandom_range(255)));
                hot = addr;
            end else begin
                send(OP_RAM_RD, addr, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic port_burst();
        int r;
        repeat ($urandom_range(2, 10)) begin
            r = $urandom_range(99);
            if (r < 25) begin
                send(OP_REG_WR, reg_addr(REG_CMD), {TCMD_NOP, 6'($urandom_range(63))});
            end else if (r < 55) begin
                send(OP_REG_WR, reg_addr(3'($urandom_range(REG_PA, REG_PC))),
                     8'($urandom_range(255)));
            end else begin
                send(OP_REG_RD, reg_addr(3'($urandom_range(REG_PA, REG_PC))),
                     8'($urandom_range(255)));
            end
        end
    endtask

    task automatic random_phase(int target);
        int r;
        while (n_sent < target) begin
            r = $urandom_range(99);
            if (r < 55) timer_burst();
            else if (r < 75) ram_burst();
            else if (r < 90) port_burst();
            else send_noise();
        end
    endtask

    function automatic void add_row(logic [2:0] op, logic [7:0] addr, logic [7:0] data,
                                    logic [7:0] pa, logic [5:0] pc,
                                    logic typed, out_t value);
        dir_row_t row;
        row.item.opcode     = op;
        row.item.address    = addr;
        row.item.write_data = data;
        row.item.pa_pins    = pa;
        row.item.pb_pins    = ~pa;
        row.item.pc_pins    = pc;
        row.typed           = typed;
        row.value           = value;
        dir_rows.push_back(row);
    endfunction

    function automatic void build_rows();
        // idle after reset, pin high
        add_row(OP_TICK,   8'h00, 8'h00, 8'h00, 6'h00, 1'b1,
                {8'h00, 8'h00, 8'h00, 6'h00, 4'b0001});
        add_row(OP_REG_RD, {5'h00, REG_CMD}, 8'h00, 8'h00, 6'h00, 1'b1,
                {8'h00, 8'h00, 8'h00, 6'h00, 4'b0001});
        add_row(OP_REG_RD, {5'h00, REG_PC}, 8'h00, 8'h00, 6'h3f, 1'b1,
                {8'hff, 8'h00, 8'h00, 6'h00, 4'b0001});
        add_row(OP_REG_RD, {5'h1f, REG_PA}, 8'h00, 8'hff, 6'h00, 1'b1,
                {8'hff, 8'h00, 8'h00, 6'h00, 4'b0001});
        add_row(OP_RAM_WR, 8'hff, 8'hff, 8'h00, 6'h00, 1'b1,
                {8'h00, 8'h00, 8'h00, 6'h00, 4'b0001});
        add_row(OP_RAM_RD, 8'hff, 8'h00, 8'h00, 6'h00, 1'b1,
                {8'hff, 8'h00, 8'h00, 6'h00, 4'b0001});
        add_row(OP_RAM_RD, 8'h00, 8'h00, 8'h00, 6'h00, 1'b1,
                {8'h00, 8'h00, 8'h00, 6'h00, 4'b0001});
        add_row(OP_UNUSED, 8'hff, 8'hff, 8'hff, 6'h3f, 1'b1,
                {8'h00, 8'h00, 8'h00, 6'h00, 4'b0001});
        add_row(OP_REG_RD, {5'h1f, REG_NONE}, 8'h00, 8'h00, 6'h00, 1'b1,
                {8'h00, 8'h00, 8'h00, 6'h00, 4'b0001});
        // latch written while the port is an input
        add_row(OP_REG_WR, {5'h00, REG_PA}, 8'hff, 8'h00, 6'h00, 1'b1,
                {8'h00, 8'hff, 8'h00, 6'h00, 4'b0001});
        add_row(OP_REG_RD, {5'h00, REG_PA}, 8'h00, 8'h00, 6'h00, 1'b1,
                {8'h00, 8'hff, 8'h00, 6'h00, 4'b0001});
        // start with a zero count stops at once
        add_row(OP_REG_WR, {5'h00, REG_CMD}, {TCMD_START, 6'h00}, 8'h00, 6'h00, 1'b1,
                {8'h00, 8'hff, 8'h00, 6'h00, 4'b0001});
        add_row(OP_REG_WR, {5'h00, REG_PC}, 8'hff, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_REG_WR, {5'h00, REG_CMD}, {TCMD_NOP, 6'h0f}, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_REG_RD, {5'h00, REG_PC}, 8'h00, 8'h00, 6'h00, 1'b0, '0);
        // strobed port c mode
        add_row(OP_REG_WR, {5'h00, REG_CMD}, {TCMD_NOP, 6'h08}, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_REG_RD, {5'h00, REG_PC}, 8'h00, 8'h00, 6'h3f, 1'b0, '0);
        // pulse mode with auto reload, count 4
        add_row(OP_REG_WR, {5'h00, REG_TLO}, 8'h04, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_REG_WR, {5'h00, REG_THI}, 8'hc0, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_REG_WR, {5'h00, REG_CMD}, {TCMD_START, 6'h03}, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_TICK,   8'h00, 8'h00, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_TICK,   8'hff, 8'hff, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_REG_RD, {5'h00, REG_TLO}, 8'h00, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_REG_WR, {5'h00, REG_CMD}, {TCMD_STOP, 6'h03}, 8'h00, 6'h00, 1'b0, '0);
        add_row(OP_REG_RD, {5'h00, REG_THI}, 8'h00, 8'h00, 6'h00, 1'b0, '0);
    endfunction

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        row_typed  = 1'b0;
        row_value  = '0;
        errors     = 0;
        n_sent     = 0;
        n_accepted = 0;
        n_checked  = 0;
        n_ticks    = 0;
        n_tc       = 0;
        s_idle_pct = 38;
        m_idle_pct = 74;
        model_init();
        build_rows();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].value);
        random_phase(PHASE_ITEMS);
        s_idle_pct = 74;
        m_idle_pct = 38;
        random_phase(2 * PHASE_ITEMS);
        s_idle_pct = 0;
        m_idle_pct = 0;
        random_phase(3 * PHASE_ITEMS);
        s_valid <= 1'b0;

        while (snapshot_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d items (%0d timer ticks, %0d terminal counts predicted)",
                 n_accepted, n_ticks, n_tc);
        $display("checked %0d results under three handshake pacing phases", n_checked);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
